// File: hw/rtl/jacd_pkg.sv
`timescale 1ns / 1ps

package jacd_pkg;

    // Geometry of the data path.
    localparam int NUM_AXES_DEF = 2;
    localparam int SAMPLE_W     = 12;
    localparam int QUO_W        = 12;
    localparam int DIV_STEPS    = QUO_W;
    localparam int NUM_W        = SAMPLE_W + DIV_STEPS - 1;
    localparam int CNT_W        = $clog2(DIV_STEPS);
    localparam int CFG_ADDR_W   = 2;
    localparam int TDATA_W      = ((SAMPLE_W + 7) / 8) * 8;

    // Mapping constants.
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [SAMPLE_W-1:0] MID_LOW    = 12'd2047;

    // Register reset values.
    localparam logic [SAMPLE_W-1:0] CENTER_X_RST = 12'd1895;
    localparam logic [SAMPLE_W-1:0] CENTER_Y_RST = 12'd1793;
    localparam logic [SAMPLE_W-1:0] DEADBAND_RST = 12'((4096 / 128) - 1);

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEADBAND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DECIDE,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
    } t_dp_status;

endpackage

// File: hw/rtl/jacd_datapath.sv
`timescale 1ns / 1ps

module jacd_datapath #(
    parameter int NUM_AXES = jacd_pkg::NUM_AXES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [jacd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [jacd_pkg::SAMPLE_W-1:0]    i_cfg_wdata,
    input  logic                             i_in_axis,
    input  logic [jacd_pkg::SAMPLE_W-1:0]    i_in_sample,
    input  jacd_pkg::t_dp_cmd                i_cmd,
    output jacd_pkg::t_dp_status             o_status,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_out_axis,
    output logic [jacd_pkg::SAMPLE_W-1:0]    o_out_level
);
    import jacd_pkg::*;

    logic [SAMPLE_W-1:0] r_center_x;
    logic [SAMPLE_W-1:0] r_center_y;
    logic [SAMPLE_W-1:0] r_deadband;
    logic [SAMPLE_W-1:0] r_level [NUM_AXES];

    logic                r_axis;
    logic                r_upper;
    logic                r_zero;
    logic [NUM_W-1:0]    r_rem;
    logic [NUM_W-1:0]    r_dvs;
    logic [QUO_W-1:0]    r_quo;

    logic                r_out_valid;
    logic                r_out_axis;
    logic [SAMPLE_W-1:0] r_out_level;

    logic [SAMPLE_W-1:0] center;
    logic                upper;
    logic [NUM_W-1:0]    samp_ext;
    logic [NUM_W-1:0]    n_rem_load;
    logic [NUM_W-1:0]    n_dvs_load;
    logic                ge;
    logic [SAMPLE_W-1:0] mapped;
    logic [SAMPLE_W-1:0] level_cur;
    logic [SAMPLE_W-1:0] diff;
    logic                axis_ok;
    logic                out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= CENTER_X_RST;
            r_center_y <= CENTER_Y_RST;
            r_deadband <= DEADBAND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CENTER_X: r_center_x <= i_cfg_wdata;
                CFG_CENTER_Y: r_center_y <= i_cfg_wdata;
                CFG_DEADBAND: r_deadband <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The numerator is the scaled sample offset, the divisor the segment span.
    // Both are aligned so that the quotient falls out in twelve restoring steps.
    always_comb begin
        center   = i_in_axis ? r_center_y : r_center_x;
        upper    = i_in_sample > center;
        samp_ext = NUM_W'(i_in_sample);
        if (upper) begin
            n_rem_load = NUM_W'(i_in_sample - center) << (DIV_STEPS - 1);
            n_dvs_load = NUM_W'(FULL_SCALE - center) << (DIV_STEPS - 1);
        end else begin
            n_rem_load = (samp_ext << (SAMPLE_W - 1)) - samp_ext;
            n_dvs_load = NUM_W'(center) << (DIV_STEPS - 1);
        end
    end

    assign ge = r_rem >= r_dvs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_axis  <= i_in_axis;
            r_upper <= upper;
            r_zero  <= !upper && (center == '0);
            r_rem   <= n_rem_load;
            r_dvs   <= n_dvs_load;
            r_quo   <= '0;
        end else if (i_cmd.step) begin
            if (ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    always_comb begin
        if (r_zero) begin
            mapped = '0;
        end else if (r_upper) begin
            mapped = r_quo + MID_LOW;
        end else begin
            mapped = r_quo;
        end
    end

    always_comb begin
        level_cur = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (r_axis == 1'(i)) begin
                level_cur = r_level[i];
            end
        end
    end

    assign axis_ok = int'(r_axis) < NUM_AXES;
    assign diff    = (mapped > level_cur) ? (mapped - level_cur) : (level_cur - mapped);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_level[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                if (r_axis == 1'(i)) begin
                    r_level[i] <= mapped;
                end
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_axis  <= r_axis;
            r_out_level <= mapped;
        end
    end

    assign o_status.emit     = axis_ok && (diff > r_deadband);
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_axis        = r_out_axis;
    assign o_out_level       = r_out_level;

endmodule

// File: hw/rtl/jacd_ctrl.sv
`timescale 1ns / 1ps

module jacd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  jacd_pkg::t_dp_status  i_status,
    output jacd_pkg::t_dp_cmd     o_cmd
);
    import jacd_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_W'(DIV_STEPS - 1);
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DECIDE: begin
                if (i_status.emit) begin
                    // The level is committed now; the word may still wait for the output.
                    o_cmd.commit = 1'b1;
                    if (i_status.out_free) begin
                        o_cmd.push = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/joystick_axis_center_deadband.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports            Contents
// s_axis    in         tdata, tuser     tdata[11:0] raw_sample; tuser axis
// m_axis    out        tdata, tuser     tdata[11:0] level; tuser out_axis
// cfg       in         we, addr, wdata  0 center_x, 1 center_y, 2 deadband
//
// Each accepted word passes through a load step, twelve steps of the restoring divider
// that forms the mapped level, and one decide step.
// The divider handles one word at a time, so a new word is taken only after the last is done.
// A stalled output holds the decided word; the next input waits until it is taken.
// Reset is synchronous and active low; it restores the register defaults and clears
// both stored levels to zero.

module joystick_axis_center_deadband #(
    parameter int NUM_AXES = jacd_pkg::NUM_AXES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [jacd_pkg::TDATA_W-1:0]     i_s_axis_tdata,  // [11:0] raw_sample
    input  logic                             i_s_axis_tuser,  // [0] axis
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [jacd_pkg::TDATA_W-1:0]     o_m_axis_tdata,  // [11:0] level
    output logic                             o_m_axis_tuser,  // [0] out_axis
    input  logic                             i_cfg_we,
    input  logic [jacd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [jacd_pkg::SAMPLE_W-1:0]    i_cfg_wdata
);
    import jacd_pkg::*;

    t_dp_cmd             cmd;
    t_dp_status          status;
    logic [SAMPLE_W-1:0] out_level;

    jacd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    jacd_datapath #(
        .NUM_AXES (NUM_AXES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_axis   (i_s_axis_tuser),
        .i_in_sample (i_s_axis_tdata[SAMPLE_W-1:0]),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_axis  (o_m_axis_tuser),
        .o_out_level (out_level)
    );

    assign o_m_axis_tdata = TDATA_W'(out_level);

`ifndef SYNTHESIS
    a_no_accept_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !o_s_axis_tready)
        else $error("input accepted while the divider is running");

    a_accept_starts_division: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> cmd.step)
        else $error("accepted word did not start the divider");

    a_push_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result pushed over an untaken output word");

    a_push_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> o_m_axis_tvalid)
        else $error("pushed result not presented on the output");
`endif

endmodule
